/* hw/rtl/cts_pkg.sv */
// ----------------------------------------------------------------------------
// cts_pkg: shared types, codes and helpers of the clock time-setting unit
// Holds the packed clock state, the button event codes and the small step
// and hour-conversion functions used by the next-state logic.
// ----------------------------------------------------------------------------
`default_nettype none

package cts_pkg;

	localparam int FUNC_W     = 4;
	localparam int STATE_W    = 36;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 40;
	localparam int PAD_W      = OUT_DATA_W - STATE_W;

	// Button event codes.
	localparam logic [FUNC_W-1:0] FN_HOUR_UP    = 4'd0;
	localparam logic [FUNC_W-1:0] FN_HOUR_DN    = 4'd1;
	localparam logic [FUNC_W-1:0] FN_MINUTE_UP  = 4'd2;
	localparam logic [FUNC_W-1:0] FN_MINUTE_DN  = 4'd3;
	localparam logic [FUNC_W-1:0] FN_DAY_UP     = 4'd4;
	localparam logic [FUNC_W-1:0] FN_DAY_DN     = 4'd5;
	localparam logic [FUNC_W-1:0] FN_MONTH_UP   = 4'd6;
	localparam logic [FUNC_W-1:0] FN_MONTH_DN   = 4'd7;
	localparam logic [FUNC_W-1:0] FN_YEAR_UP    = 4'd8;
	localparam logic [FUNC_W-1:0] FN_YEAR_DN    = 4'd9;
	localparam logic [FUNC_W-1:0] FN_MODE       = 4'd10;
	localparam logic [FUNC_W-1:0] FN_ALARM      = 4'd11;
	localparam logic [FUNC_W-1:0] FN_LOAD       = 4'd12;

	// Declared top down so that the hour lands in the lowest bits.
	typedef struct packed {
		logic       alarm_on;
		logic       alm_pm;
		logic [4:0] alarm_hour;
		logic       twelve_hour;
		logic [6:0] year;
		logic [3:0] month;
		logic [4:0] day;
		logic [5:0] minute;
		logic       pm;
		logic [4:0] hour;
	} state_t;

	typedef struct packed {
		logic       pm;
		logic [4:0] hour;
	} hour_t;

	localparam state_t STATE_RESET = '{
		alarm_on:    1'b0,
		alm_pm:      1'b0,
		alarm_hour:  5'd0,
		twelve_hour: 1'b0,
		year:        7'd0,
		month:       4'd1,
		day:         5'd1,
		minute:      6'd0,
		pm:          1'b0,
		hour:        5'd0
	};

	function automatic logic [6:0] step_up(input logic [6:0] v, input logic [6:0] lo,
			input logic [6:0] hi);
		if (v >= hi || v < lo) begin
			return lo;
		end
		return v + 7'd1;
	endfunction

	function automatic logic [6:0] step_down(input logic [6:0] v, input logic [6:0] lo,
			input logic [6:0] hi);
		if (v <= lo || v > hi) begin
			return hi;
		end
		return v - 7'd1;
	endfunction

	function automatic logic [6:0] days_in(input logic [3:0] m);
		logic [6:0] d;
		unique case (m)
			4'd2:                                   d = 7'd28;
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 7'd31;
			default:                                d = 7'd30;
		endcase
		return d;
	endfunction

	// 12-hour step up: the 11-to-12 crossing flips AM/PM.
	function automatic hour_t hour12_up(input hour_t h);
		hour_t r;
		r = h;
		if (h.hour == 5'd0) begin
			r.hour = 5'd1;
		end else if (h.hour < 5'd11) begin
			r.hour = h.hour + 5'd1;
		end else if (h.hour == 5'd11) begin
			r.hour = 5'd12;
			r.pm   = ~h.pm;
		end else begin
			r.hour = 5'd1;
		end
		return r;
	endfunction

	function automatic hour_t hour12_down(input hour_t h);
		hour_t r;
		r = h;
		if (h.hour == 5'd12) begin
			r.hour = 5'd11;
			r.pm   = ~h.pm;
		end else if (h.hour >= 5'd2 && h.hour <= 5'd11) begin
			r.hour = h.hour - 5'd1;
		end else begin
			r.hour = 5'd12;
		end
		return r;
	endfunction

	// 12-hour to 24-hour; an out-of-range hour counts as 12.
	function automatic hour_t to_24(input hour_t h);
		hour_t      r;
		logic [4:0] v;
		v = (h.hour == 5'd0 || h.hour > 5'd12) ? 5'd12 : h.hour;
		r.pm = 1'b0;
		if (h.pm) begin
			r.hour = (v == 5'd12) ? 5'd12 : v + 5'd12;
		end else begin
			r.hour = (v == 5'd12) ? 5'd0 : v;
		end
		return r;
	endfunction

	// 24-hour to 12-hour; an hour above 23 counts as 23.
	function automatic hour_t to_12(input hour_t h);
		hour_t      r;
		logic [4:0] v;
		v = (h.hour > 5'd23) ? 5'd23 : h.hour;
		if (v == 5'd0) begin
			r.hour = 5'd12;
			r.pm   = 1'b0;
		end else if (v < 5'd12) begin
			r.hour = v;
			r.pm   = 1'b0;
		end else if (v == 5'd12) begin
			r.hour = 5'd12;
			r.pm   = 1'b1;
		end else begin
			r.hour = v - 5'd12;
			r.pm   = 1'b1;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/cts_step.sv */
// ----------------------------------------------------------------------------
// cts_step: next-state logic of the clock time-setting unit
// Applies one button event to the current clock state in a single pass.
// ----------------------------------------------------------------------------
`default_nettype none

module cts_step
	import cts_pkg::*;
(
	input  wire logic [FUNC_W-1:0] func,
	input  wire state_t            load,
	input  wire state_t            cur,
	output state_t                 nxt
);

	hour_t clk_h;
	hour_t alm_h;
	hour_t clk_up;
	hour_t clk_dn;

	assign clk_h  = '{pm: cur.pm, hour: cur.hour};
	assign alm_h  = '{pm: cur.alm_pm, hour: cur.alarm_hour};
	assign clk_up = hour12_up(clk_h);
	assign clk_dn = hour12_down(clk_h);

	always_comb begin
		hour_t c;
		hour_t a;
		c   = clk_h;
		a   = alm_h;
		nxt = cur;
		unique case (func)
			FN_HOUR_UP: begin
				if (cur.twelve_hour) begin
					nxt.hour = clk_up.hour;
					nxt.pm   = clk_up.pm;
				end else begin
					nxt.hour = 5'(step_up({2'b0, cur.hour}, 7'd0, 7'd23));
				end
			end
			FN_HOUR_DN: begin
				if (cur.twelve_hour) begin
					nxt.hour = clk_dn.hour;
					nxt.pm   = clk_dn.pm;
				end else begin
					nxt.hour = 5'(step_down({2'b0, cur.hour}, 7'd0, 7'd23));
				end
			end
			FN_MINUTE_UP: nxt.minute = 6'(step_up({1'b0, cur.minute}, 7'd0, 7'd59));
			FN_MINUTE_DN: nxt.minute = 6'(step_down({1'b0, cur.minute}, 7'd0, 7'd59));
			FN_DAY_UP:    nxt.day = 5'(step_up({2'b0, cur.day}, 7'd1, days_in(cur.month)));
			FN_DAY_DN:    nxt.day = 5'(step_down({2'b0, cur.day}, 7'd1, days_in(cur.month)));
			FN_MONTH_UP:  nxt.month = 4'(step_up({3'b0, cur.month}, 7'd1, 7'd12));
			FN_MONTH_DN:  nxt.month = 4'(step_down({3'b0, cur.month}, 7'd1, 7'd12));
			FN_YEAR_UP:   nxt.year = step_up(cur.year, 7'd0, 7'd99);
			FN_YEAR_DN:   nxt.year = step_down(cur.year, 7'd0, 7'd99);
			FN_MODE: begin
				// Clock and alarm hours are converted the same way.
				if (cur.twelve_hour) begin
					c = to_24(clk_h);
					a = to_24(alm_h);
				end else begin
					c = to_12(clk_h);
					a = to_12(alm_h);
				end
				nxt.hour        = c.hour;
				nxt.pm          = c.pm;
				nxt.alarm_hour  = a.hour;
				nxt.alm_pm      = a.pm;
				nxt.twelve_hour = ~cur.twelve_hour;
			end
			FN_ALARM: nxt.alarm_on = ~cur.alarm_on;
			FN_LOAD: begin
				nxt        = load;
				nxt.pm     = load.twelve_hour & load.pm;
				nxt.alm_pm = load.twelve_hour & load.alm_pm;
			end
			default: nxt = cur;
		endcase
	end

endmodule

`default_nettype wire

/* hw/rtl/clock_time_setting_unit_top.sv */
// ----------------------------------------------------------------------------
// clock_time_setting_unit_top: clock time-setting unit
// Holds the clock and alarm settings and applies one button event per transfer.
// ----------------------------------------------------------------------------
// Each input transfer carries one button event (s_tuser) and the values used
// by a load (s_tdata); each event produces exactly one output transfer with
// the complete clock state after the event. An event is registered, applied
// to the state by one pass of next-state logic, and the result lands in the
// output register, from which it is offered; one event is taken every cycle
// while the output side keeps up. The state update of one event feeds the next
// directly, which is the loop that sets that rate.
`default_nettype none

module clock_time_setting_unit_top
	import cts_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// tdata: new_hour, new_pm, new_minute, new_day, new_month, new_year,
	// new_twelve_hour, new_alarm_hour, new_alm_pm, new_alarm_on, zero pad
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// tuser: func
	input  wire logic [FUNC_W-1:0]     s_tuser,

	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// tdata: hour, pm, minute, day, month, year, twelve_hour, alarm_hour,
	// alm_pm, alarm_on, zero pad
	output logic [OUT_DATA_W-1:0]      m_tdata
);

	logic              valid_s1;
	logic [FUNC_W-1:0] func_s1;
	state_t            load_s1;
	state_t            state_q;
	state_t            state_nxt;
	state_t            res_nxt;
	state_t            res_s2;
	logic              valid_s2;
	logic              advance;

	// The staged event moves on whenever the output register is free or drains.
	assign advance  = valid_s1 & (~valid_s2 | m_tready);
	assign s_tready = ~valid_s1 | advance;

	cts_step u_step (
		.func (func_s1),
		.load (load_s1),
		.cur  (state_q),
		.nxt  (state_nxt)
	);

	always_comb begin
		res_nxt        = state_nxt;
		res_nxt.pm     = state_nxt.twelve_hour & state_nxt.pm;
		res_nxt.alm_pm = state_nxt.twelve_hour & state_nxt.alm_pm;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= STATE_RESET;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				state_q  <= state_nxt;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			func_s1 <= s_tuser;
			load_s1 <= state_t'(s_tdata[STATE_W-1:0]);
		end
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{PAD_W{1'b0}}, res_s2};

endmodule

`default_nettype wire

/* dv/clock_time_setting_unit_top_tb.sv */
// ----------------------------------------------------------------------------
// clock_time_setting_unit_top_tb: self-checking bench of the time-setting unit
// Sends button events over the input stream and compares every output transfer
// with a predicted clock state. A short table of directed events covers the
// wrap points, month lengths, out-of-range loads and both hour conversions,
// then a few hundred random events follow. Both sides of the block stall at
// random.
// ----------------------------------------------------------------------------
`default_nettype none

module clock_time_setting_unit_top_tb
	import cts_pkg::*;
();

	// Codes above the load are not decoded by the block.
	localparam logic [FUNC_W-1:0] FN_UNUSED = 4'd13;
	localparam logic [FUNC_W-1:0] FN_TOP    = 4'd15;
	localparam int RANDOM_EVENTS = 400;

	typedef struct packed {
		logic       pm;
		logic [4:0] hr;
	} clock_hour_t;

	typedef struct {
		logic [FUNC_W-1:0] func;
		state_t            load;
		bit                typed;
		state_t            want;
	} event_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [FUNC_W-1:0]     s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	state_t     clock_setting;
	state_t     awaited_settings[$];
	event_row_t directed_rows[$];
	bit         tx_calm = 1'b0;
	bit         rx_calm = 1'b0;
	int         error_count = 0;
	int         events_sent = 0;
	int         loads_sent = 0;
	int         toggles_sent = 0;
	int         results_checked = 0;

	clock_time_setting_unit_top DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------
	function automatic logic [6:0] wrap_inc(input logic [6:0] v, input logic [6:0] lo,
			input logic [6:0] hi);
		if (v < lo || v >= hi) begin
			return lo;
		end
		return v + 7'd1;
	endfunction

	function automatic logic [6:0] wrap_dec(input logic [6:0] v, input logic [6:0] lo,
			input logic [6:0] hi);
		if (v > lo && v <= hi) begin
			return v - 7'd1;
		end
		return hi;
	endfunction

	// February never gets a leap day.
	function automatic logic [6:0] month_len(input logic [3:0] m);
		case (m)
			4'd2: return 7'd28;
			4'd4, 4'd6, 4'd9, 4'd11: return 7'd30;
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 7'd31;
			default: return 7'd30;
		endcase
	endfunction

	function automatic clock_hour_t advance_12h(input clock_hour_t t);
		clock_hour_t r;
		r = t;
		if (t.hr == 5'd11) begin
			r.hr = 5'd12;
			r.pm = ~t.pm;
		end else if (t.hr <= 5'd10) begin
			r.hr = (t.hr == 5'd0) ? 5'd1 : t.hr + 5'd1;
		end else begin
			r.hr = 5'd1;
		end
		return r;
	endfunction

	function automatic clock_hour_t retreat_12h(input clock_hour_t t);
		clock_hour_t r;
		r = t;
		if (t.hr == 5'd12) begin
			r.hr = 5'd11;
			r.pm = ~t.pm;
		end else if (t.hr >= 5'd2 && t.hr <= 5'd11) begin
			r.hr = t.hr - 5'd1;
		end else begin
			r.hr = 5'd12;
		end
		return r;
	endfunction

	// 12 AM is midnight, 12 PM stays noon; a bad 12-hour value reads as 12.
	function automatic clock_hour_t as_24h(input clock_hour_t t);
		clock_hour_t r;
		logic [4:0]  v;
		v = (t.hr >= 5'd1 && t.hr <= 5'd12) ? t.hr : 5'd12;
		r.pm = 1'b0;
		if (v == 5'd12) begin
			r.hr = t.pm ? 5'd12 : 5'd0;
		end else begin
			r.hr = t.pm ? v + 5'd12 : v;
		end
		return r;
	endfunction

	function automatic clock_hour_t as_12h(input clock_hour_t t);
		clock_hour_t r;
		logic [4:0]  v;
		v = (t.hr > 5'd23) ? 5'd23 : t.hr;
		r.pm = (v >= 5'd12);
		if (v == 5'd0 || v == 5'd12) begin
			r.hr = 5'd12;
		end else begin
			r.hr = (v > 5'd12) ? v - 5'd12 : v;
		end
		return r;
	endfunction

	function automatic state_t next_setting(input state_t s, input logic [FUNC_W-1:0] f,
			input state_t ld);
		state_t      n;
		clock_hour_t t;
		clock_hour_t a;
		n = s;
		t = '{pm: s.pm, hr: s.hour};
		a = '{pm: s.alm_pm, hr: s.alarm_hour};
		case (f)
			FN_HOUR_UP: begin
				if (s.twelve_hour) begin
					t = advance_12h(t);
					n.hour = t.hr;
					n.pm   = t.pm;
				end else begin
					n.hour = 5'(wrap_inc({2'b0, s.hour}, 7'd0, 7'd23));
				end
			end
			FN_HOUR_DN: begin
				if (s.twelve_hour) begin
					t = retreat_12h(t);
					n.hour = t.hr;
					n.pm   = t.pm;
				end else begin
					n.hour = 5'(wrap_dec({2'b0, s.hour}, 7'd0, 7'd23));
				end
			end
			FN_MINUTE_UP: n.minute = 6'(wrap_inc({1'b0, s.minute}, 7'd0, 7'd59));
			FN_MINUTE_DN: n.minute = 6'(wrap_dec({1'b0, s.minute}, 7'd0, 7'd59));
			FN_DAY_UP:    n.day    = 5'(wrap_inc({2'b0, s.day}, 7'd1, month_len(s.month)));
			FN_DAY_DN:    n.day    = 5'(wrap_dec({2'b0, s.day}, 7'd1, month_len(s.month)));
			FN_MONTH_UP:  n.month  = 4'(wrap_inc({3'b0, s.month}, 7'd1, 7'd12));
			FN_MONTH_DN:  n.month  = 4'(wrap_dec({3'b0, s.month}, 7'd1, 7'd12));
			FN_YEAR_UP:   n.year   = wrap_inc(s.year, 7'd0, 7'd99);
			FN_YEAR_DN:   n.year   = wrap_dec(s.year, 7'd0, 7'd99);
			FN_MODE: begin
				t = s.twelve_hour ? as_24h(t) : as_12h(t);
				a = s.twelve_hour ? as_24h(a) : as_12h(a);
				n.hour        = t.hr;
				n.pm          = t.pm;
				n.alarm_hour  = a.hr;
				n.alm_pm      = a.pm;
				n.twelve_hour = ~s.twelve_hour;
			end
			FN_ALARM: n.alarm_on = ~s.alarm_on;
			FN_LOAD: begin
				n = ld;
				if (!ld.twelve_hour) begin
					n.pm     = 1'b0;
					n.alm_pm = 1'b0;
				end
			end
			default: ;
		endcase
		return n;
	endfunction

	// The AM/PM flags only show in 12-hour mode.
	function automatic state_t displayed(input state_t s);
		state_t r;
		r = s;
		if (!s.twelve_hour) begin
			r.pm     = 1'b0;
			r.alm_pm = 1'b0;
		end
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	function automatic int pick_gap(input bit calm);
		int r;
		if (calm) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(6, 24);
	endfunction

	function automatic logic [FUNC_W-1:0] random_func();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			return FN_LOAD;
		end else if (r < 14) begin
			return FUNC_W'($urandom_range(FN_UNUSED, FN_TOP));
		end
		return FUNC_W'($urandom_range(FN_HOUR_UP, FN_ALARM));
	endfunction

	// Mostly sensible settings; now and then every bit is random.
	function automatic state_t random_load();
		state_t      d;
		logic [63:0] raw;
		if ($urandom_range(0, 4) == 0) begin
			raw = {$urandom, $urandom};
			d = raw[STATE_W-1:0];
			return d;
		end
		d.twelve_hour = 1'($urandom_range(0, 1));
		d.hour        = d.twelve_hour ? 5'($urandom_range(1, 12)) : 5'($urandom_range(0, 23));
		d.alarm_hour  = d.twelve_hour ? 5'($urandom_range(1, 12)) : 5'($urandom_range(0, 23));
		d.pm          = 1'($urandom_range(0, 1));
		d.alm_pm      = 1'($urandom_range(0, 1));
		d.alarm_on    = 1'($urandom_range(0, 1));
		d.minute      = 6'($urandom_range(0, 59));
		d.day         = 5'($urandom_range(1, 31));
		d.month       = 4'($urandom_range(1, 12));
		d.year        = 7'($urandom_range(0, 99));
		return d;
	endfunction

	function automatic void add_row(input logic [FUNC_W-1:0] f, input state_t ld,
			input bit typed, input state_t want);
		event_row_t row;
		row.func  = f;
		row.load  = ld;
		row.typed = typed;
		row.want  = want;
		directed_rows.push_back(row);
	endfunction

	// Offers one event and, once the transfer happens, records what must come back.
	task automatic send_event(input logic [FUNC_W-1:0] f, input state_t ld, input bit typed,
			input state_t want);
		int gap;
		gap = pick_gap(tx_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= f;
		s_tdata  <= {{(IN_DATA_W - STATE_W){1'b0}}, ld};
		do @(posedge clk); while (!s_tready);
		clock_setting = next_setting(clock_setting, f, ld);
		awaited_settings.push_back(typed ? want : displayed(clock_setting));
		events_sent++;
		if (f == FN_LOAD) begin
			loads_sent++;
		end
		if (f == FN_MODE) begin
			toggles_sent++;
		end
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			error_count++;
		end
	endtask

	// ------------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		state_t want;
		state_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[STATE_W-1:0];
			if (awaited_settings.size() == 0) begin
				$error("result transfer with no event outstanding: %h", m_tdata);
				error_count++;
			end else begin
				want = awaited_settings.pop_front();
				check_field("hour", 32'(want.hour), 32'(got.hour));
				check_field("pm", 32'(want.pm), 32'(got.pm));
				check_field("minute", 32'(want.minute), 32'(got.minute));
				check_field("day", 32'(want.day), 32'(got.day));
				check_field("month", 32'(want.month), 32'(got.month));
				check_field("year", 32'(want.year), 32'(got.year));
				check_field("twelve_hour", 32'(want.twelve_hour), 32'(got.twelve_hour));
				check_field("alarm_hour", 32'(want.alarm_hour), 32'(got.alarm_hour));
				check_field("alm_pm", 32'(want.alm_pm), 32'(got.alm_pm));
				check_field("alarm_on", 32'(want.alarm_on), 32'(got.alarm_on));
				results_checked++;
			end
		end
	end

	// Output side: runs of ready broken by stalls, with calm stretches in between.
	initial begin : result_sink
		int gap;
		int burst;
		burst = 0;
		@(posedge arst_n);
		forever begin
			rx_calm = ((burst / 12) % 3) == 2;
			gap = pick_gap(rx_calm);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst++;
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin : event_source
		state_t s;
		state_t ld;
		int     i;
		clock_setting = STATE_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Wrap points of every field from the reset state.
		s = STATE_RESET;
		s.hour = 5'd23;        add_row(FN_HOUR_DN, '0, 1'b1, s);
		s.hour = 5'd0;         add_row(FN_HOUR_UP, '0, 1'b1, s);
		s.minute = 6'd59;      add_row(FN_MINUTE_DN, '0, 1'b1, s);
		s.minute = 6'd0;       add_row(FN_MINUTE_UP, '0, 1'b1, s);
		s.day = 5'd31;         add_row(FN_DAY_DN, '0, 1'b1, s);
		s.day = 5'd1;          add_row(FN_DAY_UP, '0, 1'b1, s);
		s.month = 4'd12;       add_row(FN_MONTH_DN, '0, 1'b1, s);
		s.month = 4'd1;        add_row(FN_MONTH_UP, '0, 1'b1, s);
		s.year = 7'd99;        add_row(FN_YEAR_DN, '0, 1'b1, s);
		s.year = 7'd0;         add_row(FN_YEAR_UP, '0, 1'b1, s);
		s.alarm_on = 1'b1;     add_row(FN_ALARM, '0, 1'b1, s);
		s.hour = 5'd12;
		s.alarm_hour = 5'd12;
		s.twelve_hour = 1'b1;  add_row(FN_MODE, '0, 1'b1, s);

		// Every field loaded above its range, then stepped and converted.
		s = '1;                add_row(FN_LOAD, s, 1'b1, s);
		add_row(FN_HOUR_UP, '0, 1'b0, '0);
		add_row(FN_MINUTE_DN, '0, 1'b0, '0);
		add_row(FN_DAY_UP, '0, 1'b0, '0);
		add_row(FN_MODE, '0, 1'b0, '0);

		// 11 AM on the last day of February: noon crossing both ways, short month.
		ld = STATE_RESET;
		ld.twelve_hour = 1'b1;
		ld.hour = 5'd11;
		ld.month = 4'd2;
		ld.day = 5'd28;
		add_row(FN_LOAD, ld, 1'b0, '0);
		add_row(FN_HOUR_UP, '0, 1'b0, '0);
		add_row(FN_HOUR_DN, '0, 1'b0, '0);
		add_row(FN_DAY_UP, '0, 1'b0, '0);
		add_row(FN_DAY_DN, '0, 1'b0, '0);

		// 24-hour load drops the PM flags; noon and 23:00 convert to 12 PM and 11 PM.
		ld = STATE_RESET;
		ld.hour = 5'd12;
		ld.pm = 1'b1;
		ld.alarm_hour = 5'd23;
		ld.alm_pm = 1'b1;
		add_row(FN_LOAD, ld, 1'b0, '0);
		add_row(FN_MODE, '0, 1'b0, '0);
		add_row(FN_UNUSED, '0, 1'b0, '0);

		// A 12-hour hour of zero and a day of zero in month zero.
		ld = '0;
		ld.twelve_hour = 1'b1;
		add_row(FN_LOAD, ld, 1'b0, '0);
		add_row(FN_HOUR_DN, '0, 1'b0, '0);
		add_row(FN_DAY_DN, '0, 1'b0, '0);

		foreach (directed_rows[r]) begin
			send_event(directed_rows[r].func, directed_rows[r].load, directed_rows[r].typed,
				directed_rows[r].want);
		end

		for (i = 0; i < RANDOM_EVENTS; i++) begin
			tx_calm = ((i / 40) % 4) == 1;
			if (i == RANDOM_EVENTS / 2) begin
				// Let the block drain completely before going on.
				s_tvalid <= 1'b0;
				wait (awaited_settings.size() == 0);
			end
			send_event(random_func(), random_load(), 1'b0, '0);
		end
		s_tvalid <= 1'b0;

		wait (awaited_settings.size() == 0);
		repeat (8) @(posedge clk);
		$display("Sent %0d button events (%0d loads, %0d mode toggles); %0d results compared.",
			events_sent, loads_sent, toggles_sent, results_checked);
		$display("Covered wrap at both ends of each field, month lengths, bad loads");
		$display("and both hour conversions.");
		if (error_count == 0) begin
			$display("PASS clock_time_setting_unit_top");
		end else begin
			$display("FAIL clock_time_setting_unit_top");
		end
		$finish;
	end

	initial begin : watchdog
		#1000000;
		$display("FAIL clock_time_setting_unit_top");
		$finish;
	end

endmodule

`default_nettype wire
